// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg: shared types, constants and byte functions
// Payload structs, S-box tables, GF(2^8) helpers and the round constants.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int unsigned RoundCount = 10;
  localparam int unsigned KeyWords   = 4 * (RoundCount + 1);
  localparam int unsigned RkAddrW    = $clog2(KeyWords);
  localparam int unsigned RoundW     = $clog2(RoundCount + 1);

  localparam logic [1:0] CfgKeyHigh = 2'd0;
  localparam logic [1:0] CfgKeyLow  = 2'd1;
  localparam logic [1:0] CfgDecrypt = 2'd2;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_beat_t;

  // Key expansion status toward the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } kx_status_t;

  function automatic logic [7:0] sbox_fwd(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] i);
    logic [7:0] r;
    case (i)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sbyte(input logic [127:0] s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aes_ram.sv =====
// ----------------------------------------------------------------------------
// aes_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/aes_keyexp.sv =====
// ----------------------------------------------------------------------------
// aes_keyexp: round key sequencer
// Expands the key one word a cycle into the key RAM, then serves reads.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_keyexp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [127:0]               key_i,
  input  wire logic [aes_pkg::RkAddrW-1:0] raddr_i,
  output logic [31:0]                     rdata_o,
  output aes_pkg::kx_status_t             status_o
);

  logic                        busy_q, busy_d;
  logic [aes_pkg::RkAddrW-1:0] idx_q, idx_d;
  logic [127:0]                win_q, win_d;   // last four words written
  logic [31:0]                 t, w_new;
  logic [3:0]                  rc_idx;
  logic                        we;
  logic [aes_pkg::RkAddrW-1:0] addr;

  always_comb begin
    t      = win_q[31:0];
    rc_idx = 4'(idx_q[aes_pkg::RkAddrW-1:2] - 1'b1);
    if (idx_q[1:0] == 2'd0) begin
      t = {aes_pkg::sbox_fwd(t[23:16]), aes_pkg::sbox_fwd(t[15:8]),
           aes_pkg::sbox_fwd(t[7:0]), aes_pkg::sbox_fwd(t[31:24])};
      t[31:24] = t[31:24] ^ aes_pkg::rcon(rc_idx);
    end
    w_new = (idx_q < 4) ? key_i[127-32*idx_q[1:0] -: 32] : (win_q[127:96] ^ t);
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    win_d  = win_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      win_d = {win_q[95:0], w_new};
      idx_d = idx_q + 1'b1;
      if (idx_q == aes_pkg::RkAddrW'(aes_pkg::KeyWords - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign we   = busy_q;
  assign addr = busy_q ? idx_q : raddr_i;

  aes_ram #(.Width(32), .Depth(aes_pkg::KeyWords)) u_rk_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(w_new),
    .rdata_o(rdata_o)
  );

  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && (idx_q == aes_pkg::RkAddrW'(aes_pkg::KeyWords - 1));

endmodule

`default_nettype wire

// ===== rtl/aes_round.sv =====
// ----------------------------------------------------------------------------
// aes_round: shared round unit
// One full encryption or decryption round on the 128-bit state per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round (
  input  wire logic [127:0] state_i,
  input  wire logic [127:0] rkey_i,
  input  wire logic         decrypt_i,
  input  wire logic         last_i,
  output logic      [127:0] state_o
);

  logic [7:0]   sh [16];
  logic [7:0]   sb [16];
  logic [7:0]   m  [16];
  logic [127:0] mixed, keyed;
  logic [7:0]   a0, a1, a2, a3, t, u, v;

  always_comb begin
    u = 8'h00;
    v = 8'h00;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (decrypt_i) begin
          sh[4*c+r] = aes_pkg::sbyte(state_i, 4*((c+3*r)%4)+r);
        end else begin
          sh[4*c+r] = aes_pkg::sbyte(state_i, 4*((c+r)%4)+r);
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = decrypt_i ? aes_pkg::sbox_inv(sh[i]) : aes_pkg::sbox_fwd(sh[i]);
    end
    // decrypt adds the key before the inverse mix
    for (int i = 0; i < 16; i++) begin
      keyed[127-8*i -: 8] = sb[i] ^ (decrypt_i ? rkey_i[127-8*i -: 8] : 8'h00);
    end
    for (int c = 0; c < 4; c++) begin
      a0 = keyed[127-32*c -: 8];
      a1 = keyed[119-32*c -: 8];
      a2 = keyed[111-32*c -: 8];
      a3 = keyed[103-32*c -: 8];
      if (decrypt_i) begin
        u  = aes_pkg::xtime(aes_pkg::xtime(a0 ^ a2));
        v  = aes_pkg::xtime(aes_pkg::xtime(a1 ^ a3));
        a0 = a0 ^ u;
        a1 = a1 ^ v;
        a2 = a2 ^ u;
        a3 = a3 ^ v;
      end
      t = a0 ^ a1 ^ a2 ^ a3;
      m[4*c]   = a0 ^ aes_pkg::xtime(a0 ^ a1) ^ t;
      m[4*c+1] = a1 ^ aes_pkg::xtime(a1 ^ a2) ^ t;
      m[4*c+2] = a2 ^ aes_pkg::xtime(a2 ^ a3) ^ t;
      m[4*c+3] = a3 ^ aes_pkg::xtime(a3 ^ a0) ^ t;
    end
    for (int i = 0; i < 16; i++) begin
      mixed[127-8*i -: 8] = m[i];
    end
    if (last_i) begin
      state_o = decrypt_i ? keyed : (keyed ^ rkey_i);
    end else begin
      state_o = decrypt_i ? mixed : (mixed ^ rkey_i);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aes128_block_cipher.sv =====
// ----------------------------------------------------------------------------
// aes128_block_cipher: AES-128 ECB core
// Iterative core with one shared round unit and a key RAM.
// ----------------------------------------------------------------------------
// A block runs from accept to result valid as follows: for the initial key
// addition and each of the ten rounds, the core fetches the round key words
// from the single-port key RAM (four reads, one word per cycle, with
// registered read data) and then applies the key; it then moves the result
// into the output register. The input is ready again as the result appears,
// so the next block is accepted only after this one has left the core, while
// the output drains. After a key write, the next block first waits while the
// key is expanded one word per cycle into the RAM. A finished block holds in
// the core while the previous result still waits in the output register.
`default_nettype none

module aes128_block_cipher (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [63:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire aes_pkg::in_beat_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output aes_pkg::out_beat_t       out_data_o
);

  typedef enum logic [2:0] {
    StIdle, StKeyStart, StKeyWait, StFetch, StApply, StOut
  } state_e;

  state_e                      state_q;
  logic [63:0]                 key_hi_q, key_lo_q;
  logic                        dec_q, keys_ok_q;
  logic [127:0]                st_q, rk_q;
  logic [aes_pkg::RoundW-1:0]  rnd_q;
  logic [2:0]                  wcnt_q;    // fetch counter: issue 0..3, capture 1..4
  logic [aes_pkg::RkAddrW-1:0] raddr;
  logic [31:0]                 rdata;
  logic [127:0]                rnd_out;
  logic                        kx_start;
  aes_pkg::kx_status_t         kx_st;
  logic [aes_pkg::RoundW-1:0]  rk_sel;
  logic                        out_vld_q;
  aes_pkg::out_beat_t          out_q;
  logic                        out_load;

  // round key number for this step
  assign rk_sel = dec_q ? aes_pkg::RoundW'(aes_pkg::RoundCount) - rnd_q : rnd_q;
  assign raddr  = aes_pkg::RkAddrW'({rk_sel, 2'b00}) + aes_pkg::RkAddrW'(wcnt_q[1:0]);
  assign kx_start = (state_q == StKeyStart);
  // hand the finished block over once the output slot is free or draining
  assign out_load = (state_q == StOut) && (!out_vld_q || out_ready_i);

  aes_keyexp u_keyexp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kx_start),
    .key_i   ({key_hi_q, key_lo_q}),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .status_o(kx_st)
  );

  aes_round u_round (
    .state_i  (st_q),
    .rkey_i   (rk_q),
    .decrypt_i(dec_q),
    .last_i   (rnd_q == aes_pkg::RoundW'(aes_pkg::RoundCount)),
    .state_o  (rnd_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      key_hi_q  <= '0;
      key_lo_q  <= '0;
      dec_q     <= 1'b0;
      keys_ok_q <= 1'b0;
      rnd_q     <= '0;
      wcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          aes_pkg::CfgKeyHigh: begin
            key_hi_q  <= cfg_wdata_i;
            keys_ok_q <= 1'b0;
          end
          aes_pkg::CfgKeyLow: begin
            key_lo_q  <= cfg_wdata_i;
            keys_ok_q <= 1'b0;
          end
          aes_pkg::CfgDecrypt: dec_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            rnd_q   <= '0;
            wcnt_q  <= '0;
            state_q <= keys_ok_q ? StFetch : StKeyStart;
          end
        end
        StKeyStart: state_q <= StKeyWait;
        StKeyWait: begin
          if (kx_st.done) begin
            keys_ok_q <= 1'b1;
            state_q   <= StFetch;
          end
        end
        StFetch: begin
          wcnt_q <= wcnt_q + 1'b1;
          if (wcnt_q == 3'd4) begin
            state_q <= StApply;
          end
        end
        StApply: begin
          wcnt_q <= '0;
          if (rnd_q == aes_pkg::RoundW'(aes_pkg::RoundCount)) begin
            state_q <= StOut;
          end else begin
            rnd_q   <= rnd_q + 1'b1;
            state_q <= StFetch;
          end
        end
        StOut: begin
          if (out_load) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath: state, key window and output register
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      st_q <= in_data_i;
    end
    if (state_q == StFetch && wcnt_q != 3'd0) begin
      rk_q <= {rk_q[95:0], rdata};
    end
    if (state_q == StApply) begin
      // initial key addition is a plain xor
      st_q <= (rnd_q == '0) ? (st_q ^ rk_q) : rnd_out;
    end
    if (out_load) begin
      out_q <= st_q;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/aes_checker.sv =====
// ----------------------------------------------------------------------------
// aes_checker: port-level checks
// Watches the top-level handshakes over time.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire aes_pkg::out_beat_t out_data_o
);

  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_o, out_valid_o})) else $error("handshake output unknown");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed");

  // an accepted block keeps the input closed for its rounds
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o [*60])
    else $error("input ready too early");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !in_valid_i |=> in_ready_o) else $error("ready dropped without a beat");

endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for aes128_block_cipher
// Drives a directed table (known answers, key/direction writes, ignored
// register index) and then random phases of key/direction settings with
// random blocks. Every result beat is checked against its known answer or
// against a behavioral AES-128 model kept in the bench, with random stalls on both channels.
// ----------------------------------------------------------------------------

module tb;

  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int unsigned RandomBlocks = 1700;

  typedef struct packed {
    logic        is_write;
    logic [1:0]  index;
    logic [63:0] wdata;
    logic [127:0] block;
    logic        known;
    logic [127:0] answer;
  } step_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_index_i = '0;
  logic [63:0]         cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  aes_pkg::in_beat_t   in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  aes_pkg::out_beat_t  out_data_o;

  aes128_block_cipher dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Model state
  logic [7:0]   fwd_tab [256];
  logic [7:0]   inv_tab [256];
  logic [63:0]  key_hi_q, key_lo_q;
  logic         decrypt_q;
  logic [31:0]  sched [44];
  logic         sched_valid;

  logic [127:0] pending_results [$];
  int           errors = 0;
  int           blocks_sent = 0;
  int           hold_left = 0;
  bit           pressure_done = 0;

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  // Build both S-boxes from the field inverse and the affine map.
  function void build_sboxes();
    logic [7:0] v, s;
    for (int a = 0; a < 256; a++) begin
      v = 8'h00;
      for (int b = 1; b < 256; b++)
        if (gmul(a[7:0], b[7:0]) == 8'h01) v = b[7:0];
      s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]} ^ {v[3:0], v[7:4]} ^ 8'h63;
      fwd_tab[a] = s;
      inv_tab[s] = a[7:0];
    end
  endfunction

  function void expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    sched[0] = key_hi_q[63:32];
    sched[1] = key_hi_q[31:0];
    sched[2] = key_lo_q[63:32];
    sched[3] = key_lo_q[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_tab[t[31:24]], fwd_tab[t[23:16]], fwd_tab[t[15:8]], fwd_tab[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = dbl(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
    sched_valid = 1'b1;
  endfunction

  function logic [127:0] sub_all(input logic [127:0] x, input bit inv);
    for (int i = 0; i < 16; i++)
      x[127-8*i -: 8] = inv ? inv_tab[x[127-8*i -: 8]] : fwd_tab[x[127-8*i -: 8]];
    return x;
  endfunction

  function automatic logic [127:0] shift_all(input logic [127:0] x, input bit inv);
    logic [127:0] y;
    int k;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        k = 4 * ((c + (inv ? 3 : 1) * r) % 4) + r;
        y[127-8*(4*c+r) -: 8] = x[127-8*k -: 8];
      end
    return y;
  endfunction

  function automatic logic [127:0] mix_all(input logic [127:0] x, input bit inv);
    logic [7:0] p0, p1, p2, p3, t, u, v;
    for (int c = 0; c < 4; c++) begin
      {p0, p1, p2, p3} = x[127-32*c -: 32];
      if (inv) begin
        u = dbl(dbl(p0 ^ p2));
        v = dbl(dbl(p1 ^ p3));
        p0 ^= u; p1 ^= v; p2 ^= u; p3 ^= v;
      end
      t = p0 ^ p1 ^ p2 ^ p3;
      x[127-32*c -: 32] = {p0 ^ dbl(p0 ^ p1) ^ t, p1 ^ dbl(p1 ^ p2) ^ t,
                           p2 ^ dbl(p2 ^ p3) ^ t, p3 ^ dbl(p3 ^ p0) ^ t};
    end
    return x;
  endfunction

  function logic [127:0] round_key(input int r);
    return {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
  endfunction

  function logic [127:0] crypt_block(input logic [127:0] x);
    if (!sched_valid) expand_schedule();
    if (!decrypt_q) begin
      x ^= round_key(0);
      for (int r = 1; r < 10; r++)
        x = mix_all(shift_all(sub_all(x, 0), 0), 0) ^ round_key(r);
      x = shift_all(sub_all(x, 0), 0) ^ round_key(10);
    end else begin
      x ^= round_key(10);
      for (int r = 9; r > 0; r--)
        x = mix_all(sub_all(shift_all(x, 1), 1) ^ round_key(r), 1);
      x = sub_all(shift_all(x, 1), 1) ^ round_key(0);
    end
    return x;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      aes_pkg::CfgKeyHigh: begin key_hi_q = data; sched_valid = 1'b0; end
      aes_pkg::CfgKeyLow:  begin key_lo_q = data; sched_valid = 1'b0; end
      aes_pkg::CfgDecrypt: decrypt_q = data[0];
      default: ;
    endcase
  endtask

  // Drop valid and wait for every outstanding result before touching registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_block(input logic [127:0] blk, input bit known, input logic [127:0] ans);
    logic [127:0] want;
    bit calm;
    calm = blocks_sent >= 300 && blocks_sent < 500;
    if (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= blk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = crypt_block(blk);
    pending_results.push_back(known ? ans : want);
    blocks_sent++;
  endtask

  function automatic logic [127:0] rand_block();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Receiver: random stalls, one quiet window and one long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat %h", out_data_o);
          errors++;
        end else begin
          logic [127:0] want;
          want = pending_results.pop_front();
          if (out_data_o.result_high !== want[127:64]) begin
            $error("result_high expected %h actual %h", want[127:64], out_data_o.result_high);
            errors++;
          end
          if (out_data_o.result_low !== want[63:0]) begin
            $error("result_low expected %h actual %h", want[63:0], out_data_o.result_low);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!pressure_done && blocks_sent >= 800) begin
        pressure_done = 1;
        hold_left = 400;
        out_ready_i <= 1'b0;
      end else if (blocks_sent >= 300 && blocks_sent < 500) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin
    #20ms;
    $display("aes128_block_cipher verification failed");
    $finish;
  end

  initial begin
    step_row_t rows [$];
    int n;
    build_sboxes();
    key_hi_q = '0; key_lo_q = '0; decrypt_q = 1'b0; sched_valid = 1'b0;
    for (int i = 0; i < 44; i++) sched[i] = '0;

    // Known answers come from the standard's published vectors.
    rows = '{
      '{0, 2'd0, 64'h0, 128'h0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
      '{0, 2'd0, 64'h0, '1, 0, 128'h0},
      '{1, CfgUnused, '1, 128'h0, 0, 128'h0},
      '{0, 2'd0, 64'h0, 128'h0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
      '{1, aes_pkg::CfgKeyHigh, 64'h0001020304050607, 128'h0, 0, 128'h0},
      '{1, aes_pkg::CfgKeyLow, 64'h08090a0b0c0d0e0f, 128'h0, 0, 128'h0},
      '{0, 2'd0, 64'h0, 128'h00112233445566778899aabbccddeeff, 1,
        128'h69c4e0d86a7b0430d8cdb78070b4c55a},
      '{1, aes_pkg::CfgDecrypt, '1, 128'h0, 0, 128'h0},
      '{0, 2'd0, 64'h0, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1,
        128'h00112233445566778899aabbccddeeff},
      '{0, 2'd0, 64'h0, '1, 0, 128'h0},
      '{1, aes_pkg::CfgDecrypt, 64'h2, 128'h0, 0, 128'h0},
      '{0, 2'd0, 64'h0, '1, 0, 128'h0},
      '{1, aes_pkg::CfgKeyHigh, '1, 128'h0, 0, 128'h0},
      '{1, aes_pkg::CfgKeyLow, '1, 128'h0, 0, 128'h0},
      '{0, 2'd0, 64'h0, 128'h0, 0, 128'h0},
      '{0, 2'd0, 64'h0, '1, 0, 128'h0},
      '{1, aes_pkg::CfgDecrypt, 64'h1, 128'h0, 0, 128'h0},
      '{0, 2'd0, 64'h0, 128'h0, 0, 128'h0},
      '{0, 2'd0, 64'h0, 128'h8000000000000001_0000000000000001, 0, 128'h0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_write) begin
        drain();
        write_reg(rows[i].index, rows[i].wdata);
      end else begin
        send_block(rows[i].block, rows[i].known, rows[i].answer);
      end
    end

    n = 0;
    while (n < RandomBlocks) begin
      drain();
      if ($urandom_range(3) != 0) write_reg(aes_pkg::CfgKeyHigh, rand_word());
      if ($urandom_range(3) != 0) write_reg(aes_pkg::CfgKeyLow, rand_word());
      if ($urandom_range(1)) write_reg(aes_pkg::CfgDecrypt, {$urandom, $urandom});
      if ($urandom_range(15) == 0) write_reg(CfgUnused, rand_word());
      repeat ($urandom_range(1, 40)) begin
        send_block(rand_block(), 0, '0);
        n++;
      end
    end
    drain();
    repeat (80) @(posedge clk_i);

    if (errors == 0) begin
      $display("aes128_block_cipher verification clean");
    end else begin
      $display("aes128_block_cipher verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/aes_pkg.sv
rtl/aes_ram.sv
rtl/aes_keyexp.sv
rtl/aes_round.sv
rtl/aes128_block_cipher.sv
rtl/aes_checker.sv
sim/tb.sv
